// File: sv/block_dequant_idct_recon_macros.svh
// assertion macros used by the block's top-level rtl file
`ifndef BLOCK_DEQUANT_IDCT_RECON_MACROS_SVH
`define BLOCK_DEQUANT_IDCT_RECON_MACROS_SVH

// same-cycle implication, checked out of reset
`define BDIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bdir check failed");

// next-cycle implication, checked out of reset
`define BDIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bdir check failed");

`endif

// File: sv/bdir_pkg.sv
// package: widths, tables and types of the dequantize / idct / reconstruct block
`default_nettype none
package bdir_pkg;

    localparam int COEF_BITS     = 12;
    localparam int COS_FRAC_BITS = 15;

    // cosine factor width (signed q1.F) and its digit split
    localparam int KW     = COS_FRAC_BITS + 1;
    localparam int DIG_W  = 4;
    localparam int DIG_N  = (KW + DIG_W - 1) / DIG_W;
    localparam int KX     = DIG_N * DIG_W;
    localparam int DIG_CW = (DIG_N > 1) ? $clog2(DIG_N) : 1;

    // operand, product and accumulator widths
    localparam int OPW = 24;
    localparam int PW  = OPW + KX;
    localparam int AW  = PW + 4;

    // rounding of the row pass and truncation of the column pass
    localparam int ROW_SH  = COS_FRAC_BITS - 8;
    localparam int COL_SH  = COS_FRAC_BITS + 8;
    localparam int Q30_SH  = 30 - COS_FRAC_BITS;

    localparam int CFG_IDX_W = 4;
    localparam int NUM_GROUPS = 8;

    // zigzag position to natural position
    localparam logic [5:0] NAT_POS [64] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    // |cos(m*pi/16)| in q1.30, m = 0..8
    localparam logic [31:0] COS_MAG_Q30 [9] = '{
        32'd1073741824, 32'd1053110176, 32'd992008094, 32'd892783698,
        32'd759250125,  32'd596538995,  32'd410903207, 32'd209476638,
        32'd0
    };

    // control word from the sequencer to the serial mac
    typedef struct packed {
        logic load;
        logic step;
        logic acc;
        logic clr;
    } t_mac_ctl;

    // cosine factor K[i][j], column 0 holds 1/sqrt2
    function automatic logic signed [KW-1:0] cos_k(input logic [2:0] i, input logic [2:0] j);
        logic [7:0]  m_full;
        logic [4:0]  m;
        logic [3:0]  mi;
        logic        neg;
        logic [31:0] rnd;
        logic [KW-1:0] mag;
        m_full = (({5'd0, i} << 1) + 8'd1) * {5'd0, j};
        m      = m_full[4:0];
        neg    = 1'b0;
        if (j == 3'd0) begin
            mi = 4'd4;
        end else if (m <= 5'd8) begin
            mi = m[3:0];
        end else if (m <= 5'd16) begin
            mi = 4'(5'd16 - m);
            neg = 1'b1;
        end else if (m <= 5'd24) begin
            mi = 4'(m - 5'd16);
            neg = 1'b1;
        end else begin
            mi = 4'(6'd32 - {1'b0, m});
        end
        rnd = (COS_MAG_Q30[mi] + (32'd1 << (Q30_SH - 1))) >> Q30_SH;
        mag = rnd[KW-1:0];
        return neg ? -signed'(mag) : signed'(mag);
    endfunction

endpackage
`default_nettype wire

// File: sv/bdir_if.sv
// handshake channels: input word, output word and configuration write
`default_nettype none
interface bdir_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bdir_pkg::COEF_BITS-1:0] coefficient;
    logic        [7:0]                     predicted_pixel;
    modport source (output valid, output coefficient, output predicted_pixel, input ready);
    modport sink   (input valid, input coefficient, input predicted_pixel, output ready);
endinterface

interface bdir_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       last_of_block;
    modport source (output valid, output pixel, output last_of_block, input ready);
    modport sink   (input valid, input pixel, input last_of_block, output ready);
endinterface

interface bdir_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bdir_pkg::CFG_IDX_W-1:0]     index;
    logic [63:0]                        data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/block_dequant_idct_recon.sv
// top level: 8x8 dequantize, two-pass inverse dct and reconstruction
//
//  channel  dir  payload                          handshake
//  i_in     in   coefficient, predicted_pixel     valid/ready
//  o_out    out  pixel, last_of_block             valid/ready
//  i_cfg    in   index, data (quant group)        valid/ready
//
// 64 words load at one per cycle; then the transform runs 128 outputs
// of 8 terms on the single digit-serial mac (address, operand load, one
// step per factor digit, accumulate per term; a finish step per output).
// no words load until the column pass ends; a stalled output holds it.
// reset is synchronous and clears control, quant and mac acc registers.
`default_nettype none
`include "block_dequant_idct_recon_macros.svh"
module block_dequant_idct_recon (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bdir_in_if.sink    i_in,
    bdir_out_if.source o_out,
    bdir_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_ROW  = 3'b010,
        ST_COL  = 3'b100
    } t_state;

    // term phases: address, operand load, one step per factor digit, accumulate
    localparam logic [3:0] PH_ADDR = 4'd0;
    localparam logic [3:0] PH_OPND = 4'd1;
    localparam logic [3:0] PH_D0   = 4'd2;
    localparam logic [3:0] PH_ACC  = 4'(2 + bdir_pkg::DIG_N);
    localparam logic [3:0] PH_FIN  = 4'(3 + bdir_pkg::DIG_N);

    localparam logic signed [bdir_pkg::AW-1:0] WMAX = (bdir_pkg::AW'(1) <<< 23) - 1;
    localparam logic signed [bdir_pkg::AW-1:0] WMIN = -(bdir_pkg::AW'(1) <<< 23);

    t_state      r_state;
    logic [5:0]  r_cnt;
    logic [5:0]  r_o;
    logic [2:0]  r_t;
    logic [3:0]  r_ph;
    logic [63:0] r_quant [bdir_pkg::NUM_GROUPS];

    logic [bdir_pkg::COEF_BITS+5:0]  coef_mem [64];
    logic [7:0]                      pred_mem [64];
    logic [23:0]                     work_mem [64];
    logic [bdir_pkg::COEF_BITS+5:0]  r_coef_rd;
    logic [23:0]                     r_work_rd;
    logic [7:0]                      r_pred_rd;

    logic       r_out_valid;
    logic [7:0] r_pixel;
    logic       r_last;

    logic       in_acc;
    logic       out_free;
    logic       is_row;
    logic       fin;
    logic [5:0] rd_addr;
    logic signed [bdir_pkg::KW-1:0]  factor;
    logic signed [bdir_pkg::OPW-1:0] opnd;
    logic signed [bdir_pkg::AW-1:0]  acc;
    bdir_pkg::t_mac_ctl mac_ctl;

    logic [5:0]                            zz;
    logic signed [bdir_pkg::COEF_BITS-1:0] cf;
    logic [7:0]                            q;
    logic signed [bdir_pkg::COEF_BITS+8:0] dq_p;
    logic [bdir_pkg::COEF_BITS+8:0]        dq_mag;
    logic [bdir_pkg::COEF_BITS+8:0]        dq_rnd;
    logic signed [bdir_pkg::COEF_BITS+8:0] dq;

    logic signed [bdir_pkg::AW-1:0] row_r;
    logic [23:0]                    row_sat;
    logic [bdir_pkg::AW-1:0]        col_mag;
    logic signed [bdir_pkg::AW-1:0] col_t;
    logic signed [bdir_pkg::AW-1:0] col_sum;
    logic [7:0]                     pix;

    // handshakes
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_LOAD);
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_out.ready;
    assign is_row      = (r_state == ST_ROW);
    assign fin         = (r_ph == PH_FIN) && (is_row || out_free);

    // quant group registers, out-of-range indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < bdir_pkg::NUM_GROUPS; g++) begin
                r_quant[g] <= '0;
            end
        end else if (i_cfg.valid && (i_cfg.index < bdir_pkg::CFG_IDX_W'(bdir_pkg::NUM_GROUPS))) begin
            r_quant[i_cfg.index[2:0]] <= i_cfg.data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_o     <= '0;
            r_t     <= '0;
            r_ph    <= PH_ADDR;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 6'd63) begin
                            r_state <= ST_ROW;
                            r_o     <= '0;
                            r_t     <= '0;
                            r_ph    <= PH_ADDR;
                        end
                    end
                end
                ST_ROW, ST_COL: begin
                    if (r_ph == PH_ACC) begin
                        r_ph <= (r_t == 3'd7) ? PH_FIN : PH_ADDR;
                        r_t  <= r_t + 1'b1;
                    end else if (r_ph == PH_FIN) begin
                        if (fin) begin
                            r_ph <= PH_ADDR;
                            r_o  <= r_o + 1'b1;
                            if (r_o == 6'd63) begin
                                r_state <= is_row ? ST_COL : ST_LOAD;
                            end
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // term address and cosine factor
    always_comb begin
        if (is_row) begin
            rd_addr = {r_o[5:3], r_t};
            factor  = bdir_pkg::cos_k(r_o[2:0], r_t);
        end else begin
            rd_addr = {r_t, r_o[2:0]};
            factor  = bdir_pkg::cos_k(r_o[5:3], r_t);
        end
    end

    // block stores, registered reads
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            coef_mem[bdir_pkg::NAT_POS[r_cnt]] <= {r_cnt, i_in.coefficient};
            pred_mem[r_cnt] <= i_in.predicted_pixel;
        end
        if (is_row && fin) begin
            work_mem[r_o] <= row_sat;
        end
        r_coef_rd <= coef_mem[rd_addr];
        r_work_rd <= work_mem[rd_addr];
        r_pred_rd <= pred_mem[r_o];
    end

    // dequantize: round half away from zero of coef*q/4
    always_comb begin
        zz     = r_coef_rd[bdir_pkg::COEF_BITS +: 6];
        cf     = signed'(r_coef_rd[bdir_pkg::COEF_BITS-1:0]);
        q      = r_quant[zz[5:3]][zz[2:0]*8 +: 8];
        dq_p   = cf * signed'({1'b0, q});
        dq_mag = dq_p[bdir_pkg::COEF_BITS+8] ? unsigned'(-dq_p) : unsigned'(dq_p);
        dq_rnd = (dq_mag + 2'd2) >> 2;
        dq     = dq_p[bdir_pkg::COEF_BITS+8] ? -signed'(dq_rnd) : signed'(dq_rnd);
        opnd   = is_row ? bdir_pkg::OPW'(dq) : signed'(r_work_rd);
    end

    // mac control
    always_comb begin
        mac_ctl.load = (r_ph == PH_OPND);
        mac_ctl.step = (r_ph >= PH_D0) && (r_ph < PH_ACC);
        mac_ctl.acc  = (r_ph == PH_ACC);
        mac_ctl.clr  = fin;
    end

    bdir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_opnd   (opnd),
        .i_factor (factor),
        .o_acc    (acc)
    );

    // row finish: round to 8 fraction bits and saturate to 24 bits
    always_comb begin
        row_r = (acc + (signed'(bdir_pkg::AW'(1)) <<< (bdir_pkg::ROW_SH - 1)))
                >>> bdir_pkg::ROW_SH;
        if (row_r > WMAX) begin
            row_sat = 24'h7fffff;
        end else if (row_r < WMIN) begin
            row_sat = 24'h800000;
        end else begin
            row_sat = row_r[23:0];
        end
    end

    // column finish: truncate toward zero, add prediction, clamp
    always_comb begin
        col_mag = acc[bdir_pkg::AW-1] ? unsigned'(-acc) : unsigned'(acc);
        col_mag = col_mag >> bdir_pkg::COL_SH;
        col_t   = acc[bdir_pkg::AW-1] ? -signed'(col_mag) : signed'(col_mag);
        col_sum = col_t + signed'(bdir_pkg::AW'(r_pred_rd));
        if (col_sum < 0) begin
            pix = 8'd0;
        end else if (col_sum > 255) begin
            pix = 8'd255;
        end else begin
            pix = col_sum[7:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!is_row && (r_state == ST_COL) && fin) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_COL) && fin) begin
            r_pixel <= pix;
            r_last  <= (r_o == 6'd63);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pixel         = r_pixel;
    assign o_out.last_of_block = r_last;

    // checks
    `BDIR_ASSERT_NEXT(a_start_row, in_acc && (r_cnt == 6'd63), r_state == ST_ROW)
    `BDIR_ASSERT_NOW(a_cnt_clear, r_state != ST_LOAD, r_cnt == 6'd0)
    `BDIR_ASSERT_NEXT(a_col_emit, (r_state == ST_COL) && fin, o_out.valid)
    `BDIR_ASSERT_NOW(a_fin_term, r_ph == PH_FIN, r_t == 3'd0)

endmodule
`default_nettype wire

// File: sv/bdir_mac.sv
// digit-serial multiply-accumulate: one 4-bit factor digit per cycle, msb digit first
`default_nettype none
module bdir_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bdir_pkg::t_mac_ctl                i_ctl,
    input  wire logic signed [bdir_pkg::OPW-1:0]   i_opnd,
    input  wire logic signed [bdir_pkg::KW-1:0]    i_factor,
    output logic signed [bdir_pkg::AW-1:0]         o_acc
);

    logic signed [bdir_pkg::OPW-1:0]       r_a;
    logic signed [bdir_pkg::KX-1:0]        r_k;
    logic signed [bdir_pkg::PW-1:0]        r_prod;
    logic signed [bdir_pkg::AW-1:0]        r_acc;
    logic [bdir_pkg::DIG_CW-1:0]           r_dig;
    logic [bdir_pkg::DIG_W-1:0]            nib;
    logic signed [bdir_pkg::DIG_W:0]       digit;
    logic signed [bdir_pkg::OPW+bdir_pkg::DIG_W:0] part;

    // current digit: top digit signed, the rest unsigned
    always_comb begin
        nib = r_k[r_dig*bdir_pkg::DIG_W +: bdir_pkg::DIG_W];
        if (r_dig == bdir_pkg::DIG_CW'(bdir_pkg::DIG_N - 1)) begin
            digit = {nib[bdir_pkg::DIG_W-1], nib};
        end else begin
            digit = {1'b0, nib};
        end
        part = r_a * digit;
    end

    // digit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig <= '0;
        end else if (i_ctl.load) begin
            r_dig <= bdir_pkg::DIG_CW'(bdir_pkg::DIG_N - 1);
        end else if (i_ctl.step) begin
            r_dig <= r_dig - 1'b1;
        end
    end

    // operands and horner product
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a    <= i_opnd;
            r_k    <= bdir_pkg::KX'(i_factor);
            r_prod <= '0;
        end else if (i_ctl.step) begin
            r_prod <= (r_prod <<< bdir_pkg::DIG_W) + bdir_pkg::PW'(part);
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + bdir_pkg::AW'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire
